### rtl/octree_key_operation_unit_defines.svh
// ----------------------------------------------------------------------------
// Octree key operation unit: assertion macros
// Shared property shorthands for the key unit checks, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef OCTREE_KEY_OPERATION_UNIT_DEFINES_SVH
`define OCTREE_KEY_OPERATION_UNIT_DEFINES_SVH

// pre holds -> post holds on the following clock
`define OKOU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// pre holds -> post holds on the same clock
`define OKOU_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

### rtl/okou_pkg.sv
// ----------------------------------------------------------------------------
// Octree key operation unit package
// Key and transfer types, opcodes and small shift/bit helpers.
// ----------------------------------------------------------------------------
package okou_pkg;

  localparam int KEY_BITS = 32;
  localparam int DEPTH_W  = 6;
  localparam int POS_W    = $clog2(KEY_BITS);

  typedef logic [KEY_BITS-1:0] coord_t;
  typedef logic [DEPTH_W-1:0]  depth_t;

  // opcodes
  localparam logic [3:0] OP_XOR        = 4'd0;
  localparam logic [3:0] OP_DIFFIDX    = 4'd1;
  localparam logic [3:0] OP_ANCESTOR   = 4'd2;
  localparam logic [3:0] OP_CHILD      = 4'd3;
  localparam logic [3:0] OP_FATHER     = 4'd4;
  localparam logic [3:0] OP_OCTANT     = 4'd5;
  localparam logic [3:0] OP_DIST       = 4'd6;
  localparam logic [3:0] OP_FIRSTCHILD = 4'd7;
  localparam logic [3:0] OP_ISANC      = 4'd8;
  localparam logic [3:0] OP_PRECEDE    = 4'd9;
  localparam logic [3:0] OP_EQ         = 4'd10;
  localparam logic [3:0] OP_NEIGH      = 4'd11;
  localparam logic [3:0] OP_PARENT     = 4'd12;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [5:0]  a_depth;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [5:0]  b_depth;
    logic [2:0]  child_oct;
    logic        a_present;
  } req_t;

  typedef struct packed {
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [5:0]  r_depth;
    logic [31:0] r_value;
    logic        r_flag;
    logic [2:0]  r_octant;
  } rsp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    depth_t d;
  } key_t;

  // shifts of KEY_BITS or more clear the coordinate
  function automatic coord_t kshl(input coord_t v, input depth_t s);
    kshl = (s >= DEPTH_W'(KEY_BITS)) ? '0 : (v << s);
  endfunction

  function automatic coord_t kshr(input coord_t v, input depth_t s);
    kshr = (s >= DEPTH_W'(KEY_BITS)) ? '0 : (v >> s);
  endfunction

  function automatic logic bit_at(input coord_t v, input depth_t pos);
    bit_at = (pos >= DEPTH_W'(KEY_BITS)) ? 1'b0 : v[pos[POS_W-1:0]];
  endfunction

  // index of highest set bit plus one, zero for zero
  function automatic depth_t bitlen(input coord_t v);
    depth_t n;
    n = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (v[i]) n = DEPTH_W'(i + 1);
    end
    bitlen = n;
  endfunction

endpackage

### rtl/okou_core.sv
// ----------------------------------------------------------------------------
// Octree key operation unit: operation core
// Combinational evaluation of one request: key alignment, xor, first
// differing bit and the per-opcode result selection.
// ----------------------------------------------------------------------------
module okou_core (
  input  okou_pkg::req_t req,
  output okou_pkg::rsp_t rsp
);

  okou_pkg::key_t a, b, au, bu, adn, bdn, xr, deep;
  logic           a_deeper, b_deeper;
  okou_pkg::depth_t ddiff, dmax, idx, bl_x, bl_y, bl_z, pos;
  okou_pkg::coord_t dx, dy, dz, dmx;
  logic [2:0]     oct_au, oct_bu;

  assign a = '{x: req.a_x, y: req.a_y, z: req.a_z, d: req.a_depth};
  assign b = '{x: req.b_x, y: req.b_y, z: req.b_z, d: req.b_depth};

  assign a_deeper = a.d > b.d;
  assign b_deeper = a.d < b.d;
  assign ddiff    = a_deeper ? (a.d - b.d) : (b.d - a.d);
  assign dmax     = a_deeper ? a.d : b.d;

  // up-aligned to the deeper depth
  always_comb begin
    au = a;
    bu = b;
    if (b_deeper) begin
      au.x = okou_pkg::kshl(a.x, ddiff);
      au.y = okou_pkg::kshl(a.y, ddiff);
      au.z = okou_pkg::kshl(a.z, ddiff);
    end
    if (a_deeper) begin
      bu.x = okou_pkg::kshl(b.x, ddiff);
      bu.y = okou_pkg::kshl(b.y, ddiff);
      bu.z = okou_pkg::kshl(b.z, ddiff);
    end
    au.d = dmax;
    bu.d = dmax;
  end

  // down-aligned to the shallower depth
  always_comb begin
    adn = a;
    bdn = b;
    if (a_deeper) begin
      adn.x = okou_pkg::kshr(a.x, ddiff);
      adn.y = okou_pkg::kshr(a.y, ddiff);
      adn.z = okou_pkg::kshr(a.z, ddiff);
    end
    if (b_deeper) begin
      bdn.x = okou_pkg::kshr(b.x, ddiff);
      bdn.y = okou_pkg::kshr(b.y, ddiff);
      bdn.z = okou_pkg::kshr(b.z, ddiff);
    end
  end

  assign xr.x = au.x ^ bu.x;
  assign xr.y = au.y ^ bu.y;
  assign xr.z = au.z ^ bu.z;
  assign xr.d = dmax;

  assign bl_x = okou_pkg::bitlen(xr.x);
  assign bl_y = okou_pkg::bitlen(xr.y);
  assign bl_z = okou_pkg::bitlen(xr.z);

  always_comb begin
    idx = bl_x;
    if (bl_y > idx) idx = bl_y;
    if (bl_z > idx) idx = bl_z;
  end

  assign deep = b_deeper ? b : a;

  assign dx = (adn.x < bdn.x) ? (bdn.x - adn.x) : (adn.x - bdn.x);
  assign dy = (adn.y < bdn.y) ? (bdn.y - adn.y) : (adn.y - bdn.y);
  assign dz = (adn.z < bdn.z) ? (bdn.z - adn.z) : (adn.z - bdn.z);

  always_comb begin
    dmx = dx;
    if (dy > dmx) dmx = dy;
    if (dz > dmx) dmx = dz;
  end

  // octants at the first differing level of the aligned keys
  assign pos    = idx - okou_pkg::DEPTH_W'(1);
  assign oct_au = {okou_pkg::bit_at(au.z, pos), okou_pkg::bit_at(au.y, pos),
                   okou_pkg::bit_at(au.x, pos)};
  assign oct_bu = {okou_pkg::bit_at(bu.z, pos), okou_pkg::bit_at(bu.y, pos),
                   okou_pkg::bit_at(bu.x, pos)};

  function automatic logic near1(input okou_pkg::coord_t p, input okou_pkg::coord_t q);
    okou_pkg::coord_t d0, d1;
    d0 = p - q;
    d1 = q - p;
    near1 = (d0 <= okou_pkg::coord_t'(1)) || (d1 <= okou_pkg::coord_t'(1));
  endfunction

  always_comb begin
    rsp = '0;
    case (req.req_type)
      okou_pkg::OP_XOR: begin
        rsp.r_x     = xr.x;
        rsp.r_y     = xr.y;
        rsp.r_z     = xr.z;
        rsp.r_depth = xr.d;
      end
      okou_pkg::OP_DIFFIDX: begin
        rsp.r_value = 32'(idx);
      end
      okou_pkg::OP_ANCESTOR: begin
        rsp.r_x     = okou_pkg::kshr(deep.x, idx);
        rsp.r_y     = okou_pkg::kshr(deep.y, idx);
        rsp.r_z     = okou_pkg::kshr(deep.z, idx);
        rsp.r_depth = (deep.d > idx) ? (deep.d - idx) : '0;
      end
      okou_pkg::OP_CHILD: begin
        if (req.a_present) begin
          rsp.r_x     = {a.x[okou_pkg::KEY_BITS-2:0], req.child_oct[0]};
          rsp.r_y     = {a.y[okou_pkg::KEY_BITS-2:0], req.child_oct[1]};
          rsp.r_z     = {a.z[okou_pkg::KEY_BITS-2:0], req.child_oct[2]};
          rsp.r_depth = a.d + okou_pkg::DEPTH_W'(1);
        end
      end
      okou_pkg::OP_FATHER: begin
        if (req.a_present) begin
          rsp.r_x = a.x | okou_pkg::kshl(okou_pkg::coord_t'(req.child_oct[0]), a.d);
          rsp.r_y = a.y | okou_pkg::kshl(okou_pkg::coord_t'(req.child_oct[1]), a.d);
          rsp.r_z = a.z | okou_pkg::kshl(okou_pkg::coord_t'(req.child_oct[2]), a.d);
          rsp.r_depth = a.d + okou_pkg::DEPTH_W'(1);
        end else begin
          rsp.r_x     = okou_pkg::coord_t'(req.child_oct[0]);
          rsp.r_y     = okou_pkg::coord_t'(req.child_oct[1]);
          rsp.r_z     = okou_pkg::coord_t'(req.child_oct[2]);
          rsp.r_depth = okou_pkg::DEPTH_W'(1);
        end
      end
      okou_pkg::OP_OCTANT: begin
        rsp.r_octant = {au.z > bu.z, au.y > bu.y, au.x > bu.x};
      end
      okou_pkg::OP_DIST: begin
        rsp.r_value = dmx;
      end
      okou_pkg::OP_FIRSTCHILD: begin
        if (a.d != '0) begin
          rsp.r_octant = {okou_pkg::bit_at(a.z, a.d - okou_pkg::DEPTH_W'(1)),
                          okou_pkg::bit_at(a.y, a.d - okou_pkg::DEPTH_W'(1)),
                          okou_pkg::bit_at(a.x, a.d - okou_pkg::DEPTH_W'(1))};
        end
      end
      okou_pkg::OP_ISANC: begin
        // bdn is B brought down to A's depth whenever B is at least as deep
        rsp.r_flag = (b.d >= a.d) && (a.x == bdn.x) && (a.y == bdn.y) && (a.z == bdn.z);
      end
      okou_pkg::OP_PRECEDE: begin
        rsp.r_flag = (idx == '0) ? 1'b1 : (oct_au <= oct_bu);
      end
      okou_pkg::OP_EQ: begin
        rsp.r_flag = (a.d == b.d) && (a.x == b.x) && (a.y == b.y) && (a.z == b.z);
      end
      okou_pkg::OP_NEIGH: begin
        rsp.r_flag = near1(a.x, b.x) && near1(a.y, b.y) && near1(a.z, b.z);
      end
      okou_pkg::OP_PARENT: begin
        rsp.r_x     = a.x >> 1;
        rsp.r_y     = a.y >> 1;
        rsp.r_z     = a.z >> 1;
        rsp.r_depth = (a.d != '0) ? (a.d - okou_pkg::DEPTH_W'(1)) : '0;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

### rtl/octree_key_operation_unit.sv
// ----------------------------------------------------------------------------
// Octree key operation unit
// Stateless operations on pairs of 3D octree location keys.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries an opcode, key A,
//   key B, a child octant number and an A-present bit. Response channel
//   (rsp_valid / rsp_stall / rsp) carries the result key, a value, a flag
//   and an octant; fields an opcode does not produce are zero.
//   A transfer happens on a rising edge with valid high and stall low.
//   Path: a taken request is held in the input register, and its response
//   is loaded into the response register once that register is open.
//   Throughput: one request per cycle while rsp_stall is low; the whole
//   operation is one pass of the core logic between the two registers.
//   Reset (rst, synchronous) empties both registers; requests held in them
//   are dropped, not replayed, because the unit holds no other state.
//   When the receiver stalls, the response register holds its transfer and
//   an empty input register still fills once, so one more request is taken
//   before req_stall rises.
// ----------------------------------------------------------------------------
`include "octree_key_operation_unit_defines.svh"

module octree_key_operation_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  okou_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output okou_pkg::rsp_t rsp
);

  // input register
  logic           req_q_valid;
  okou_pkg::req_t req_q;

  // core result for the registered request
  okou_pkg::rsp_t rsp_next;

  // response register can take a new transfer this cycle
  logic rsp_open;

  assign rsp_open  = !rsp_valid || !rsp_stall;
  // input register frees when it is empty or drains into the response register
  assign req_stall = req_q_valid && !rsp_open;

  okou_core u_core (
    .req (req_q),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_open) begin
        rsp_valid <= req_q_valid;
      end
      if (!req_stall) begin
        req_q_valid <= req_valid;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (rsp_open && req_q_valid) begin
      rsp <= rsp_next;
    end
  end

  // a taken request always lands in the input register
  `OKOU_ASSERT_NEXT(a_req_lands, req_valid && !req_stall, req_q_valid, "accepted request not registered")

  // a held request keeps its payload until the response side opens
  `OKOU_ASSERT_NEXT(a_req_holds, req_q_valid && !rsp_open, req_q_valid && $stable(req_q), "held request lost or changed")

  // a new response only appears from an occupied input register
  `OKOU_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(req_q_valid), "response without a request")

endmodule

### verif/tb_octree_key_operation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octree key operation unit testbench
// Drives key pairs and opcodes through the request channel and checks every
// response against an in-bench model of the key arithmetic. Covers a short
// directed pass over the corner cases, then random and structurally related
// key pairs under random sender bursts and receiver stalls, and a long
// receiver hold to fill the unit.
// ----------------------------------------------------------------------------
module tb_octree_key_operation_unit;

  localparam int KEY_BITS = okou_pkg::KEY_BITS;

  // opcodes the unit does not define; they must return an all-zero response
  localparam logic [3:0] OP_UNUSED_LO = 4'd13;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  // working key: depth kept wide so intermediate sums do not wrap early
  typedef struct {
    bit [KEY_BITS-1:0] x;
    bit [KEY_BITS-1:0] y;
    bit [KEY_BITS-1:0] z;
    int unsigned       d;
  } loc_key_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  okou_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  okou_pkg::rsp_t rsp;

  okou_pkg::rsp_t op_results_due[$];
  okou_pkg::rsp_t due;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  int          hold_asks = 0;
  int          hold_taken = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  octree_key_operation_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Key arithmetic
  // --------------------------------------------------------------------------

  // shifts of a full key width or more leave nothing
  function automatic bit [KEY_BITS-1:0] coord_up(bit [KEY_BITS-1:0] v, int unsigned s);
    return (s >= KEY_BITS) ? '0 : (v << s);
  endfunction

  function automatic bit [KEY_BITS-1:0] coord_down(bit [KEY_BITS-1:0] v, int unsigned s);
    return (s >= KEY_BITS) ? '0 : (v >> s);
  endfunction

  function automatic int unsigned bit_length(bit [KEY_BITS-1:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic loc_key_t key_up(loc_key_t k, int unsigned s);
    loc_key_t r;
    r.x = coord_up(k.x, s);
    r.y = coord_up(k.y, s);
    r.z = coord_up(k.z, s);
    r.d = k.d + s;
    return r;
  endfunction

  // depth clamps at zero
  function automatic loc_key_t key_down(loc_key_t k, int unsigned s);
    loc_key_t r;
    r.x = coord_down(k.x, s);
    r.y = coord_down(k.y, s);
    r.z = coord_down(k.z, s);
    r.d = (k.d > s) ? k.d - s : 0;
    return r;
  endfunction

  // lift the shallower key to the depth of the deeper one
  function automatic void align_deeper(inout loc_key_t a, inout loc_key_t b);
    if (a.d > b.d) b = key_up(b, a.d - b.d);
    else if (a.d < b.d) a = key_up(a, b.d - a.d);
  endfunction

  function automatic loc_key_t key_xor_aligned(loc_key_t a, loc_key_t b);
    loc_key_t r;
    align_deeper(a, b);
    r.x = a.x ^ b.x;
    r.y = a.y ^ b.y;
    r.z = a.z ^ b.z;
    r.d = a.d;
    return r;
  endfunction

  // bit length of the aligned xor, highest over the three axes
  function automatic int unsigned first_diff_level(loc_key_t a, loc_key_t b);
    loc_key_t    t;
    int unsigned m;
    t = key_xor_aligned(a, b);
    m = bit_length(t.x);
    if (bit_length(t.y) > m) m = bit_length(t.y);
    if (bit_length(t.z) > m) m = bit_length(t.z);
    return m;
  endfunction

  function automatic bit [2:0] octant_of(loc_key_t k, int unsigned pos);
    bit [2:0] o;
    o[0] = 1'(coord_down(k.x, pos));
    o[1] = 1'(coord_down(k.y, pos));
    o[2] = 1'(coord_down(k.z, pos));
    return o;
  endfunction

  function automatic bit [KEY_BITS-1:0] abs_delta(bit [KEY_BITS-1:0] p, bit [KEY_BITS-1:0] q);
    return (p < q) ? q - p : p - q;
  endfunction

  // within one step either way, wrapping at the key width
  function automatic bit near_one(bit [KEY_BITS-1:0] p, bit [KEY_BITS-1:0] q);
    bit [KEY_BITS-1:0] d1;
    bit [KEY_BITS-1:0] d2;
    d1 = p - q;
    d2 = q - p;
    return (d1 <= 1) || (d2 <= 1);
  endfunction

  // response the unit owes for one request
  function automatic okou_pkg::rsp_t octree_op(okou_pkg::req_t q);
    loc_key_t          a;
    loc_key_t          b;
    loc_key_t          r;
    loc_key_t          c;
    bit [KEY_BITS-1:0] value;
    bit [KEY_BITS-1:0] dy;
    bit [KEY_BITS-1:0] dz;
    bit                flag;
    bit [2:0]          oct;
    int unsigned       idx;
    okou_pkg::rsp_t    o;

    a.x = q.a_x; a.y = q.a_y; a.z = q.a_z; a.d = q.a_depth;
    b.x = q.b_x; b.y = q.b_y; b.z = q.b_z; b.d = q.b_depth;
    r.x = '0; r.y = '0; r.z = '0; r.d = 0;
    value = '0;
    flag  = 1'b0;
    oct   = '0;

    case (q.req_type)
      okou_pkg::OP_XOR: r = key_xor_aligned(a, b);
      okou_pkg::OP_DIFFIDX: value = first_diff_level(a, b);
      okou_pkg::OP_ANCESTOR: begin
        // the deeper key is cut down; A wins a tie
        if (a.d < b.d) r = key_down(b, first_diff_level(a, b));
        else r = key_down(a, first_diff_level(a, b));
      end
      okou_pkg::OP_CHILD: begin
        if (q.a_present) begin
          r = key_up(a, 1);
          r.x = r.x | KEY_BITS'(q.child_oct[0]);
          r.y = r.y | KEY_BITS'(q.child_oct[1]);
          r.z = r.z | KEY_BITS'(q.child_oct[2]);
        end
      end
      okou_pkg::OP_FATHER: begin
        if (q.a_present) begin
          r.x = a.x | coord_up(KEY_BITS'(q.child_oct[0]), a.d);
          r.y = a.y | coord_up(KEY_BITS'(q.child_oct[1]), a.d);
          r.z = a.z | coord_up(KEY_BITS'(q.child_oct[2]), a.d);
          r.d = a.d + 1;
        end else begin
          r.x = KEY_BITS'(q.child_oct[0]);
          r.y = KEY_BITS'(q.child_oct[1]);
          r.z = KEY_BITS'(q.child_oct[2]);
          r.d = 1;
        end
      end
      okou_pkg::OP_OCTANT: begin
        align_deeper(a, b);
        oct = {a.z > b.z, a.y > b.y, a.x > b.x};
      end
      okou_pkg::OP_DIST: begin
        // Chebyshev distance at the shallower scale
        if (a.d < b.d) b = key_down(b, b.d - a.d);
        else if (a.d > b.d) a = key_down(a, a.d - b.d);
        value = abs_delta(a.x, b.x);
        dy = abs_delta(a.y, b.y);
        dz = abs_delta(a.z, b.z);
        if (dy > value) value = dy;
        if (dz > value) value = dz;
      end
      okou_pkg::OP_FIRSTCHILD: begin
        if (a.d > 0) oct = octant_of(a, a.d - 1);
      end
      okou_pkg::OP_ISANC: begin
        if (b.d >= a.d) begin
          c = key_down(b, b.d - a.d);
          flag = (a.x == c.x) && (a.y == c.y) && (a.z == c.z);
        end
      end
      okou_pkg::OP_PRECEDE: begin
        // identical aligned keys count as preceding
        idx = first_diff_level(a, b);
        if (idx == 0) begin
          flag = 1'b1;
        end else begin
          align_deeper(a, b);
          flag = octant_of(a, idx - 1) <= octant_of(b, idx - 1);
        end
      end
      okou_pkg::OP_EQ:
        flag = (a.d == b.d) && (a.x == b.x) && (a.y == b.y) && (a.z == b.z);
      okou_pkg::OP_NEIGH:
        flag = near_one(a.x, b.x) && near_one(a.y, b.y) && near_one(a.z, b.z);
      okou_pkg::OP_PARENT: r = key_down(a, 1);
      default: ;
    endcase

    o.r_x      = r.x;
    o.r_y      = r.y;
    o.r_z      = r.z;
    o.r_depth  = r.d[5:0];
    o.r_value  = value;
    o.r_flag   = flag;
    o.r_octant = oct;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request generation
  // --------------------------------------------------------------------------

  function automatic bit [KEY_BITS-1:0] depth_mask(int unsigned d);
    bit [KEY_BITS-1:0] one;
    one = 1;
    return (d >= KEY_BITS) ? '1 : ((one << d) - 1);
  endfunction

  function automatic int unsigned random_depth();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return KEY_BITS;
      2: return KEY_BITS - 1;
      default: return $urandom_range(0, KEY_BITS);
    endcase
  endfunction

  // mostly well-formed (nothing above the depth), some raw and extreme values
  function automatic bit [KEY_BITS-1:0] random_coord(int unsigned d);
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2, 3: return $urandom;
      default: return $urandom & depth_mask(d);
    endcase
  endfunction

  function automatic logic [3:0] random_op();
    if ($urandom_range(0, 39) == 0) return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    return 4'($urandom_range(okou_pkg::OP_XOR, okou_pkg::OP_PARENT));
  endfunction

  function automatic okou_pkg::req_t make_req(logic [3:0] op,
                                    logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                    int unsigned ad,
                                    logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                    int unsigned bd, int unsigned cn, bit present);
    okou_pkg::req_t item;
    item.req_type  = op;
    item.a_x       = ax;
    item.a_y       = ay;
    item.a_z       = az;
    item.a_depth   = 6'(ad);
    item.b_x       = bx;
    item.b_y       = by;
    item.b_z       = bz;
    item.b_depth   = 6'(bd);
    item.child_oct = 3'(cn);
    item.a_present = present;
    return item;
  endfunction

  function automatic okou_pkg::req_t random_item();
    int unsigned ad;
    int unsigned bd;
    ad = random_depth();
    bd = random_depth();
    return make_req(random_op(),
                    random_coord(ad), random_coord(ad), random_coord(ad), ad,
                    random_coord(bd), random_coord(bd), random_coord(bd), bd,
                    $urandom_range(0, 7), $urandom_range(0, 4) != 0);
  endfunction

  // B built from A: copy, descendant, ancestor, neighbor or sibling, so the
  // test opcodes see true answers as well as false ones
  function automatic okou_pkg::req_t related_item();
    okou_pkg::req_t    item;
    bit [KEY_BITS-1:0] ac[3];
    bit [KEY_BITS-1:0] bc[3];
    bit [KEY_BITS-1:0] tmp[3];
    int unsigned       ad;
    int unsigned       bd;
    int unsigned       k;
    int unsigned       axis;

    item = random_item();
    ad = random_depth();
    foreach (ac[i]) ac[i] = random_coord(ad);
    bc = ac;
    bd = ad;
    case ($urandom_range(0, 4))
      0: ;
      1: begin
        k = $urandom_range(0, KEY_BITS - ad);
        foreach (bc[i]) bc[i] = coord_up(ac[i], k) | ($urandom & depth_mask(k));
        bd = ad + k;
      end
      2: begin
        k = $urandom_range(0, ad);
        foreach (bc[i]) bc[i] = coord_down(ac[i], k);
        bd = ad - k;
      end
      3: begin
        foreach (bc[i]) bc[i] = ac[i] + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 3) == 0) bd = random_depth();
      end
      default: begin
        if (ad > 0) begin
          k = $urandom_range(0, ad - 1);
          axis = $urandom_range(0, 2);
          bc[axis][k] = ~bc[axis][k];
        end
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      tmp = ac; ac = bc; bc = tmp;
      k = ad; ad = bd; bd = k;
    end
    return make_req(item.req_type, ac[0], ac[1], ac[2], ad, bc[0], bc[1], bc[2], bd,
                    item.child_oct, item.a_present);
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // one transfer; a random gap may open before a new burst
  task automatic send_request(input okou_pkg::req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (op_results_due.size() != 0);
  endtask

  // accepted requests queue up what they owe
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) op_results_due.push_back(octree_op(req));
  end

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  // stall pattern switches mode every so often; a requested hold wins
  always @(posedge clk) begin
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  rsp_stall <= 1'b0;
        STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
        default:     rsp_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // each response transfer is matched against the oldest one owed
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (op_results_due.size() == 0) begin
        report_mismatch("response with nothing owed", rsp.r_value, '0);
      end else begin
        due = op_results_due.pop_front();
        if (rsp.r_x !== due.r_x) report_mismatch("r_x", rsp.r_x, due.r_x);
        if (rsp.r_y !== due.r_y) report_mismatch("r_y", rsp.r_y, due.r_y);
        if (rsp.r_z !== due.r_z) report_mismatch("r_z", rsp.r_z, due.r_z);
        if (rsp.r_depth !== due.r_depth) report_mismatch("r_depth", rsp.r_depth, due.r_depth);
        if (rsp.r_value !== due.r_value) report_mismatch("r_value", rsp.r_value, due.r_value);
        if (rsp.r_flag !== due.r_flag) report_mismatch("r_flag", rsp.r_flag, due.r_flag);
        if (rsp.r_octant !== due.r_octant)
          report_mismatch("r_octant", rsp.r_octant, due.r_octant);
      end
    end
  end

  // hard stop if the handshake hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_octree_key_operation_unit: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_directed();
    // extremes through xor, and a depth gap of a full key width
    send_request(make_req(okou_pkg::OP_XOR, '1, '1, '1, 32, 0, 0, 0, 32, 0, 1));
    send_request(make_req(okou_pkg::OP_XOR, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32,
                          '1, '1, '1, 0, 0, 1));
    // identical keys, then a difference only in bits above the depth
    send_request(make_req(okou_pkg::OP_DIFFIDX,
                          32'h000a_bcde, 32'h0001_2345, 32'h000f_0000, 20,
                          32'h000a_bcde, 32'h0001_2345, 32'h000f_0000, 20, 0, 1));
    send_request(make_req(okou_pkg::OP_DIFFIDX, 32'h8000_0000, 0, 0, 4, 0, 0, 0, 4, 0, 1));
    send_request(make_req(okou_pkg::OP_ANCESTOR, 32'h2a5, 32'h13c, 32'h3ff, 10,
                          32'ha97, 32'h4f1, 32'hffc, 12, 0, 1));
    // ancestor depth would go negative
    send_request(make_req(okou_pkg::OP_ANCESTOR, '1, '1, '1, 0, 0, 0, 0, 3, 0, 1));
    send_request(make_req(okou_pkg::OP_CHILD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31,
                          0, 0, 0, 0, 7, 1));
    send_request(make_req(okou_pkg::OP_CHILD, '1, '1, '1, 9, 0, 0, 0, 0, 5, 0));
    // depth field wraps past its top
    send_request(make_req(okou_pkg::OP_CHILD, 32'h5555_5555, 32'haaaa_aaaa, 32'h0, 63,
                          0, 0, 0, 0, 3, 1));
    send_request(make_req(okou_pkg::OP_FATHER, 32'h15, 32'h0a, 32'h1f, 5,
                          0, 0, 0, 0, 5, 1));
    send_request(make_req(okou_pkg::OP_FATHER, '1, '1, '1, 20, 0, 0, 0, 0, 6, 0));
    send_request(make_req(okou_pkg::OP_FATHER, 32'h1, 32'h2, 32'h3, 63,
                          0, 0, 0, 0, 7, 1));
    send_request(make_req(okou_pkg::OP_OCTANT, 32'hc5, 32'h11, 32'h80, 8,
                          32'h6, 32'h1, 32'h3, 3, 0, 1));
    send_request(make_req(okou_pkg::OP_DIST, '1, '1, '1, 32, 0, 0, 0, 32, 0, 1));
    // first child of the root, then of a full-depth key
    send_request(make_req(okou_pkg::OP_FIRSTCHILD, '1, '1, '1, 0, 0, 0, 0, 0, 0, 1));
    send_request(make_req(okou_pkg::OP_FIRSTCHILD, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32,
                          0, 0, 0, 0, 0, 1));
    send_request(make_req(okou_pkg::OP_ISANC, 32'h5, 32'h2, 32'h7, 3,
                          32'h2a, 32'h13, 32'h3e, 6, 0, 1));
    send_request(make_req(okou_pkg::OP_ISANC, 32'h5, 32'h2, 32'h7, 3,
                          32'h1, 32'h0, 32'h1, 2, 0, 1));
    // identical keys precede each other
    send_request(make_req(okou_pkg::OP_PRECEDE, 32'h33, 32'h44, 32'h55, 7,
                          32'h33, 32'h44, 32'h55, 7, 0, 1));
    send_request(make_req(okou_pkg::OP_PRECEDE, 32'h1f, 32'h00, 32'h0c, 5,
                          32'h0e, 32'h01, 32'h0c, 5, 0, 1));
    send_request(make_req(okou_pkg::OP_EQ, 32'h9, 32'h9, 32'h9, 4,
                          32'h9, 32'h9, 32'h9, 5, 0, 1));
    // neighbors across the wrap, keys of different depth compared raw
    send_request(make_req(okou_pkg::OP_NEIGH, 0, 32'h10, '1, 3, '1, 32'h11, 0, 30, 0, 1));
    send_request(make_req(okou_pkg::OP_PARENT, '1, '1, '1, 0, 0, 0, 0, 0, 0, 1));
    // undefined opcodes
    send_request(make_req(OP_UNUSED_LO, '1, '1, '1, 32, '1, '1, '1, 32, 7, 1));
    send_request(make_req(OP_UNUSED_HI, '1, '1, '1, 32, '1, '1, '1, 32, 7, 1));
  endtask

  task automatic test_random_ops(input int count);
    for (int n = 0; n < count; n++) send_request(random_item());
  endtask

  task automatic test_related_keys(input int count);
    for (int n = 0; n < count; n++) send_request(related_item());
  endtask

  // receiver holds off for a long stretch while requests keep coming, so the
  // unit fills and pushes back on its request side
  task automatic test_backpressure(input int count);
    no_gaps = 1'b1;
    hold_asks++;
    for (int n = 0; n < count; n++) begin
      if (n % 2 == 0) send_request(random_item());
      else send_request(related_item());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    wait_drained();
    test_random_ops(900);
    test_related_keys(700);
    wait_drained();
    test_backpressure(320);
    wait_drained();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) $display("tb_octree_key_operation_unit: PASS");
    else $display("tb_octree_key_operation_unit: FAIL");
    $finish;
  end

endmodule

### octree_key_operation_unit.f
+incdir+rtl
rtl/okou_pkg.sv
rtl/okou_core.sv
rtl/octree_key_operation_unit.sv
verif/tb_octree_key_operation_unit.sv
